// ===== rtl/mjq_pkg.sv =====
package mjq_pkg;

  // Fixed-point formats: ports are Q.FRAC_BITS, internal values carry IFB fraction bits.
  localparam int FRAC_BITS = 16;
  localparam int IFB       = 32;
  localparam int LSH       = IFB - FRAC_BITS;

  localparam logic [63:0] MAXV     = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MAXV_NEG = 64'h8000_0000_0000_0001;

  // Command queue between the front and back ends (depth is a power of two).
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);

  // Working store of the back end.
  localparam int NSLOTS = 28;
  localparam int SLOTW  = 5;
  localparam int PCW    = 7;

  // Restoring divider: dividend is a 63-bit magnitude shifted up by IFB.
  localparam int DIVN  = 63 + IFB;
  localparam int DIVCW = $clog2(DIVN + 1);

  // Working store slots.
  localparam logic [SLOTW-1:0] S_QI  = 5'd0;
  localparam logic [SLOTW-1:0] S_VI  = 5'd1;
  localparam logic [SLOTW-1:0] S_AI  = 5'd2;
  localparam logic [SLOTW-1:0] S_QF  = 5'd3;
  localparam logic [SLOTW-1:0] S_VF  = 5'd4;
  localparam logic [SLOTW-1:0] S_AF  = 5'd5;
  localparam logic [SLOTW-1:0] S_T   = 5'd6;
  localparam logic [SLOTW-1:0] S_TQ  = 5'd7;
  localparam logic [SLOTW-1:0] S_T2  = 5'd8;
  localparam logic [SLOTW-1:0] S_TA  = 5'd9;
  localparam logic [SLOTW-1:0] S_TF  = 5'd10;
  localparam logic [SLOTW-1:0] S_WF  = 5'd11;
  localparam logic [SLOTW-1:0] S_WI  = 5'd12;
  localparam logic [SLOTW-1:0] S_DQ  = 5'd13;
  localparam logic [SLOTW-1:0] S_A   = 5'd14;
  localparam logic [SLOTW-1:0] S_B   = 5'd15;
  localparam logic [SLOTW-1:0] S_C   = 5'd16;
  localparam logic [SLOTW-1:0] S_S   = 5'd17;
  localparam logic [SLOTW-1:0] S_S2  = 5'd18;
  localparam logic [SLOTW-1:0] S_S3  = 5'd19;
  localparam logic [SLOTW-1:0] S_H   = 5'd20;
  localparam logic [SLOTW-1:0] S_CS  = 5'd21;
  localparam logic [SLOTW-1:0] S_AS  = 5'd22;
  localparam logic [SLOTW-1:0] S_POS = 5'd23;
  localparam logic [SLOTW-1:0] S_VEL = 5'd24;
  localparam logic [SLOTW-1:0] S_ACC = 5'd25;
  localparam logic [SLOTW-1:0] S_Y   = 5'd26;
  localparam logic [SLOTW-1:0] S_Z   = 5'd27;

  typedef enum logic [2:0] {
    OP_LD, OP_ADD, OP_SUB, OP_KMUL, OP_MUL, OP_DIV, OP_ST, OP_END
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SLOTW-1:0] dst;
    logic [SLOTW-1:0] a;
    logic [SLOTW-1:0] b;
    logic [4:0]       k;
  } uop_t;

  typedef enum logic [1:0] {BK_IDLE, BK_FETCH, BK_EXEC, BK_WAIT} bk_state_t;

  typedef struct packed {
    logic signed [31:0] start_pos;
    logic signed [31:0] start_vel;
    logic signed [31:0] start_acc;
    logic signed [31:0] end_pos;
    logic signed [31:0] end_vel;
    logic signed [31:0] end_acc;
    logic [30:0]        duration;
    logic [30:0]        query_time;
  } item_t;

  typedef struct packed {
    logic signed [31:0] pos_out;
    logic signed [31:0] vel_out;
    logic signed [31:0] acc_out;
    logic               overflow_flag;
  } result_t;

  typedef struct packed {
    item_t item;
    logic  trivial;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } queue_head_t;

  typedef struct packed {
    logic        done;
    logic        ov;
    logic [63:0] value;
  } unit_res_t;

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // Saturate a magnitude to MAXV and apply the sign; the top bit reports saturation.
  function automatic logic [64:0] make_val(input logic [127:0] m, input logic neg);
    logic        ov;
    logic [63:0] mm;
    ov = (m > {64'b0, MAXV});
    mm = ov ? MAXV : m[63:0];
    return {ov, (neg ? -mm : mm)};
  endfunction

  function automatic uop_t mk(input op_t op, input logic [SLOTW-1:0] dst,
                              input logic [SLOTW-1:0] a, input logic [SLOTW-1:0] b,
                              input logic [4:0] k);
    uop_t u;
    u.op  = op;
    u.dst = dst;
    u.a   = a;
    u.b   = b;
    u.k   = k;
    return u;
  endfunction

  // Micro-program for one full evaluation.
  function automatic uop_t prog(input logic [PCW-1:0] pc);
    uop_t u;
    case (pc)
      7'd0:  u = mk(OP_LD,   S_QI,  S_QI,  S_QI,  5'd0);
      7'd1:  u = mk(OP_LD,   S_VI,  S_QI,  S_QI,  5'd1);
      7'd2:  u = mk(OP_LD,   S_AI,  S_QI,  S_QI,  5'd2);
      7'd3:  u = mk(OP_LD,   S_QF,  S_QI,  S_QI,  5'd3);
      7'd4:  u = mk(OP_LD,   S_VF,  S_QI,  S_QI,  5'd4);
      7'd5:  u = mk(OP_LD,   S_AF,  S_QI,  S_QI,  5'd5);
      7'd6:  u = mk(OP_LD,   S_T,   S_QI,  S_QI,  5'd6);
      7'd7:  u = mk(OP_LD,   S_TQ,  S_QI,  S_QI,  5'd7);
      7'd8:  u = mk(OP_MUL,  S_T2,  S_T,   S_T,   5'd0);
      7'd9:  u = mk(OP_MUL,  S_TA,  S_AI,  S_T2,  5'd0);
      7'd10: u = mk(OP_MUL,  S_TF,  S_AF,  S_T2,  5'd0);
      7'd11: u = mk(OP_MUL,  S_WF,  S_VF,  S_T,   5'd0);
      7'd12: u = mk(OP_MUL,  S_WI,  S_VI,  S_T,   5'd0);
      7'd13: u = mk(OP_SUB,  S_DQ,  S_QI,  S_QF,  5'd0);
      7'd14: u = mk(OP_KMUL, S_A,   S_DQ,  S_DQ,  5'd12);
      7'd15: u = mk(OP_SUB,  S_Y,   S_TA,  S_TF,  5'd0);
      7'd16: u = mk(OP_ADD,  S_A,   S_A,   S_Y,   5'd0);
      7'd17: u = mk(OP_KMUL, S_Y,   S_WF,  S_WF,  5'd6);
      7'd18: u = mk(OP_ADD,  S_A,   S_A,   S_Y,   5'd0);
      7'd19: u = mk(OP_KMUL, S_Y,   S_WI,  S_WI,  5'd6);
      7'd20: u = mk(OP_ADD,  S_A,   S_A,   S_Y,   5'd0);
      7'd21: u = mk(OP_KMUL, S_B,   S_DQ,  S_DQ,  5'd20);
      7'd22: u = mk(OP_KMUL, S_Y,   S_TA,  S_TA,  5'd3);
      7'd23: u = mk(OP_SUB,  S_Y,   S_Y,   S_TF,  5'd0);
      7'd24: u = mk(OP_ADD,  S_B,   S_B,   S_Y,   5'd0);
      7'd25: u = mk(OP_KMUL, S_Y,   S_WF,  S_WF,  5'd8);
      7'd26: u = mk(OP_ADD,  S_B,   S_B,   S_Y,   5'd0);
      7'd27: u = mk(OP_KMUL, S_Y,   S_WI,  S_WI,  5'd12);
      7'd28: u = mk(OP_ADD,  S_B,   S_B,   S_Y,   5'd0);
      7'd29: u = mk(OP_KMUL, S_C,   S_DQ,  S_DQ,  5'd30);
      7'd30: u = mk(OP_KMUL, S_Y,   S_TA,  S_TA,  5'd3);
      7'd31: u = mk(OP_KMUL, S_Z,   S_TF,  S_TF,  5'd2);
      7'd32: u = mk(OP_SUB,  S_Y,   S_Y,   S_Z,   5'd0);
      7'd33: u = mk(OP_ADD,  S_C,   S_C,   S_Y,   5'd0);
      7'd34: u = mk(OP_KMUL, S_Y,   S_WF,  S_WF,  5'd14);
      7'd35: u = mk(OP_ADD,  S_C,   S_C,   S_Y,   5'd0);
      7'd36: u = mk(OP_KMUL, S_Y,   S_WI,  S_WI,  5'd16);
      7'd37: u = mk(OP_ADD,  S_C,   S_C,   S_Y,   5'd0);
      7'd38: u = mk(OP_DIV,  S_S,   S_TQ,  S_T,   5'd0);
      7'd39: u = mk(OP_MUL,  S_S2,  S_S,   S_S,   5'd0);
      7'd40: u = mk(OP_MUL,  S_S3,  S_S2,  S_S,   5'd0);
      7'd41: u = mk(OP_MUL,  S_CS,  S_C,   S_S,   5'd0);
      7'd42: u = mk(OP_MUL,  S_AS,  S_A,   S_S2,  5'd0);
      7'd43: u = mk(OP_SUB,  S_H,   S_CS,  S_B,   5'd0);
      7'd44: u = mk(OP_SUB,  S_H,   S_H,   S_AS,  5'd0);
      7'd45: u = mk(OP_MUL,  S_POS, S_VI,  S_TQ,  5'd0);
      7'd46: u = mk(OP_MUL,  S_Y,   S_TQ,  S_TQ,  5'd0);
      7'd47: u = mk(OP_MUL,  S_Y,   S_AI,  S_Y,   5'd1);
      7'd48: u = mk(OP_ADD,  S_POS, S_QI,  S_POS, 5'd0);
      7'd49: u = mk(OP_ADD,  S_POS, S_POS, S_Y,   5'd0);
      7'd50: u = mk(OP_MUL,  S_Y,   S_S3,  S_H,   5'd1);
      7'd51: u = mk(OP_ADD,  S_POS, S_POS, S_Y,   5'd0);
      7'd52: u = mk(OP_KMUL, S_Y,   S_CS,  S_CS,  5'd4);
      7'd53: u = mk(OP_KMUL, S_Z,   S_B,   S_B,   5'd3);
      7'd54: u = mk(OP_SUB,  S_Y,   S_Y,   S_Z,   5'd0);
      7'd55: u = mk(OP_KMUL, S_Z,   S_AS,  S_AS,  5'd5);
      7'd56: u = mk(OP_SUB,  S_H,   S_Y,   S_Z,   5'd0);
      7'd57: u = mk(OP_MUL,  S_VEL, S_AI,  S_TQ,  5'd0);
      7'd58: u = mk(OP_ADD,  S_VEL, S_VI,  S_VEL, 5'd0);
      7'd59: u = mk(OP_MUL,  S_Y,   S_S2,  S_H,   5'd1);
      7'd60: u = mk(OP_DIV,  S_Y,   S_Y,   S_T,   5'd0);
      7'd61: u = mk(OP_ADD,  S_VEL, S_VEL, S_Y,   5'd0);
      7'd62: u = mk(OP_KMUL, S_Y,   S_CS,  S_CS,  5'd6);
      7'd63: u = mk(OP_KMUL, S_Z,   S_B,   S_B,   5'd3);
      7'd64: u = mk(OP_SUB,  S_Y,   S_Y,   S_Z,   5'd0);
      7'd65: u = mk(OP_KMUL, S_Z,   S_AS,  S_AS,  5'd10);
      7'd66: u = mk(OP_SUB,  S_H,   S_Y,   S_Z,   5'd0);
      7'd67: u = mk(OP_MUL,  S_Y,   S_S,   S_H,   5'd0);
      7'd68: u = mk(OP_DIV,  S_Y,   S_Y,   S_T,   5'd0);
      7'd69: u = mk(OP_DIV,  S_Y,   S_Y,   S_T,   5'd0);
      7'd70: u = mk(OP_ADD,  S_ACC, S_AI,  S_Y,   5'd0);
      7'd71: u = mk(OP_ST,   S_POS, S_POS, S_POS, 5'd0);
      7'd72: u = mk(OP_ST,   S_VEL, S_VEL, S_VEL, 5'd1);
      7'd73: u = mk(OP_ST,   S_ACC, S_ACC, S_ACC, 5'd2);
      default: u = mk(OP_END, S_QI, S_QI, S_QI, 5'd0);
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/mjq_front.sv =====
module mjq_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mjq_pkg::item_t      item,
  input  logic                pop,
  output mjq_pkg::queue_head_t head
);

  mjq_pkg::job_t            q [mjq_pkg::QDEPTH];
  logic [mjq_pkg::QPW-1:0]  wptr;
  logic [mjq_pkg::QPW-1:0]  rptr;
  logic [mjq_pkg::QPW:0]    cnt;
  logic                     push;
  mjq_pkg::job_t            job_in;

  assign busy = (cnt == (mjq_pkg::QPW + 1)'(mjq_pkg::QDEPTH));
  assign push = start && !busy;

  // A zero duration needs no arithmetic; the back end answers it at once.
  always_comb begin
    job_in.item    = item;
    job_in.trivial = (item.duration == '0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      cnt <= cnt + (mjq_pkg::QPW + 1)'(push) - (mjq_pkg::QPW + 1)'(pop);
    end
  end

  assign head.valid = (cnt != '0);
  assign head.job   = q[rptr];

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> cnt != '0)
    else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    !(cnt > (mjq_pkg::QPW + 1)'(mjq_pkg::QDEPTH)))
    else $error("queue count beyond depth");
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (busy && !pop) |=> busy)
    else $error("full queue lost an entry without a pop");

endmodule

// ===== rtl/mjq_mul.sv =====
module mjq_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [63:0]          a,
  input  logic [63:0]          b,
  input  logic                 extra,
  output mjq_pkg::unit_res_t   res
);

  logic [63:0]  x;
  logic [63:0]  y;
  logic         neg;
  logic         ext;
  logic [127:0] acc;
  logic [2:0]   cnt;
  logic         run;
  logic         done_r;
  logic         ov_r;
  logic [63:0]  val_r;
  logic [31:0]  xs;
  logic [31:0]  ys;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] qv;
  logic [64:0]  fin;

  // One 32x32 partial product per cycle, lower halves first.
  always_comb begin
    xs = cnt[0] ? x[63:32] : x[31:0];
    ys = cnt[1] ? y[63:32] : y[31:0];
    pp = 64'(xs) * 64'(ys);
    if (cnt[0] && cnt[1]) begin
      pp_sh = {pp, 64'b0};
    end else if (cnt[0] || cnt[1]) begin
      pp_sh = {32'b0, pp, 32'b0};
    end else begin
      pp_sh = {64'b0, pp};
    end
    qv  = ext ? (acc >> (mjq_pkg::IFB + 1)) : (acc >> mjq_pkg::IFB);
    fin = mjq_pkg::make_val(qv, neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      done_r <= 1'b0;
      cnt    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        if (cnt == 3'd4) begin
          run    <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= mjq_pkg::mag(a);
      y   <= mjq_pkg::mag(b);
      neg <= a[63] ^ b[63];
      ext <= extra;
      // The rounding half is preloaded into the accumulator.
      acc <= extra ? (128'd1 << mjq_pkg::IFB) : (128'd1 << (mjq_pkg::IFB - 1));
    end else if (run && cnt != 3'd4) begin
      acc <= acc + pp_sh;
    end
    if (run && cnt == 3'd4) begin
      ov_r  <= fin[64];
      val_r <= fin[63:0];
    end
  end

  assign res.done  = done_r;
  assign res.ov    = ov_r;
  assign res.value = val_r;

endmodule

// ===== rtl/mjq_div.sv =====
module mjq_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [63:0]          a,
  input  logic [63:0]          b,
  output mjq_pkg::unit_res_t   res
);

  logic [mjq_pkg::DIVN-1:0]  dv;
  logic [63:0]               d;
  logic [63:0]               rem;
  logic [62:0]               q;
  logic                      big;
  logic                      neg;
  logic                      run;
  logic [mjq_pkg::DIVCW-1:0] cnt;
  logic                      done_r;
  logic                      ov_r;
  logic [63:0]               val_r;
  logic [63:0]               xa;
  logic [63:0]               r2;
  logic                      ge;
  logic                      rnd;
  logic [63:0]               qq;
  logic [64:0]               fin;

  // Restoring division, one quotient bit per cycle. A quotient bit at or above
  // bit 63 means the result cannot be represented.
  always_comb begin
    xa  = mjq_pkg::mag(a);
    r2  = {rem[62:0], dv[mjq_pkg::DIVN-1]};
    ge  = (r2 >= d);
    rnd = ({rem[62:0], 1'b0} >= d);
    qq  = {1'b0, q} + 64'(rnd);
    fin = mjq_pkg::make_val({63'b0, big, qq}, neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      done_r <= 1'b0;
      cnt    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= mjq_pkg::DIVCW'(mjq_pkg::DIVN);
      end else if (run) begin
        if (cnt == '0) begin
          run    <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv  <= {xa[62:0], {mjq_pkg::IFB{1'b0}}};
      d   <= mjq_pkg::mag(b);
      rem <= '0;
      q   <= '0;
      big <= 1'b0;
      neg <= a[63] ^ b[63];
    end else if (run && cnt != '0) begin
      dv  <= dv << 1;
      rem <= ge ? (r2 - d) : r2;
      q   <= {q[61:0], ge};
      big <= big | (ge && cnt >= mjq_pkg::DIVCW'(64));
    end
    if (run && cnt == '0) begin
      ov_r  <= fin[64];
      val_r <= fin[63:0];
    end
  end

  assign res.done  = done_r;
  assign res.ov    = ov_r;
  assign res.value = val_r;

endmodule

// ===== rtl/mjq_back.sv =====
module mjq_back (
  input  logic                  clk,
  input  logic                  rst,
  input  mjq_pkg::queue_head_t  head,
  output logic                  pop,
  output logic                  done,
  output mjq_pkg::result_t      result
);

  mjq_pkg::bk_state_t         state;
  mjq_pkg::bk_state_t         state_next;
  logic [mjq_pkg::PCW-1:0]    pc;
  mjq_pkg::uop_t              u;
  mjq_pkg::job_t              job;
  logic                       ov;
  logic [63:0]                rf [mjq_pkg::NSLOTS];
  logic [63:0]                ra;
  logic [63:0]                rb;

  logic                       wr_en;
  logic [63:0]                wr_data;
  logic                       ov_set;
  logic                       pc_inc;
  logic                       mul_start;
  logic                       div_start;
  logic                       st_en;
  logic                       fin;
  mjq_pkg::unit_res_t         mres;
  mjq_pkg::unit_res_t         dres;
  mjq_pkg::unit_res_t         ures;

  logic [64:0]                sum;
  logic                       alu_ov;
  logic [63:0]                alu_v;
  logic [68:0]                kp;
  logic [64:0]                kres;
  logic [31:0]                sfield;
  logic [63:0]                ldv;
  logic [32:0]                sto;

  function automatic logic [32:0] store_out(input logic [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    logic        o;
    logic [31:0] w;
    m = mjq_pkg::mag(v);
    r = (m >> mjq_pkg::LSH) + 64'(m[mjq_pkg::LSH-1]);
    if (v[63]) begin
      o = (r > 64'h8000_0000);
      w = o ? 32'h8000_0000 : 32'(-r);
    end else begin
      o = (r > 64'h7fff_ffff);
      w = o ? 32'h7fff_ffff : r[31:0];
    end
    return {o, w};
  endfunction

  assign u = mjq_pkg::prog(pc);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf[u.dst] <= wr_data;
    end
    ra <= rf[u.a];
    rb <= rf[u.b];
  end

  mjq_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (ra),
    .b     (rb),
    .extra (u.k[0]),
    .res   (mres)
  );

  mjq_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (ra),
    .b     (rb),
    .res   (dres)
  );

  assign ures = (u.op == mjq_pkg::OP_MUL) ? mres : dres;

  // Saturating add and subtract, constant multiply, field load and output rounding.
  // The range is symmetric, so a sum of exactly -2^63 also counts as saturated.
  always_comb begin
    sum    = (u.op == mjq_pkg::OP_SUB) ? ({ra[63], ra} - {rb[63], rb})
                                       : ({ra[63], ra} + {rb[63], rb});
    alu_ov = (sum[64] ^ sum[63]) || (sum == {2'b11, 63'b0});
    alu_v  = !alu_ov ? sum[63:0] : (sum[64] ? mjq_pkg::MAXV_NEG : mjq_pkg::MAXV);
    kp     = 69'(mjq_pkg::mag(ra)) * 69'(u.k);
    kres   = mjq_pkg::make_val(128'(kp), ra[63]);
    case (u.k)
      5'd0:    sfield = job.item.start_pos;
      5'd1:    sfield = job.item.start_vel;
      5'd2:    sfield = job.item.start_acc;
      5'd3:    sfield = job.item.end_pos;
      5'd4:    sfield = job.item.end_vel;
      default: sfield = job.item.end_acc;
    endcase
    if (u.k >= 5'd6) begin
      ldv = {33'b0, (u.k[0] ? job.item.query_time : job.item.duration)} << mjq_pkg::LSH;
    end else begin
      ldv = {{32{sfield[31]}}, sfield} << mjq_pkg::LSH;
    end
    sto = store_out(ra);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mjq_pkg::BK_IDLE: begin
        if (head.valid && !head.job.trivial) begin
          state_next = mjq_pkg::BK_FETCH;
        end
      end
      mjq_pkg::BK_FETCH: begin
        state_next = mjq_pkg::BK_EXEC;
      end
      mjq_pkg::BK_EXEC: begin
        unique case (u.op) inside
          mjq_pkg::OP_MUL, mjq_pkg::OP_DIV: state_next = mjq_pkg::BK_WAIT;
          mjq_pkg::OP_END:                  state_next = mjq_pkg::BK_IDLE;
          default:                          state_next = mjq_pkg::BK_FETCH;
        endcase
      end
      mjq_pkg::BK_WAIT: begin
        if (ures.done) begin
          state_next = mjq_pkg::BK_FETCH;
        end
      end
      default: state_next = mjq_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    wr_en     = 1'b0;
    wr_data   = alu_v;
    ov_set    = 1'b0;
    pc_inc    = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    st_en     = 1'b0;
    fin       = 1'b0;
    unique case (state)
      mjq_pkg::BK_IDLE: begin
        pop = head.valid;
      end
      mjq_pkg::BK_FETCH: begin
      end
      mjq_pkg::BK_EXEC: begin
        unique case (u.op)
          mjq_pkg::OP_LD: begin
            wr_en   = 1'b1;
            wr_data = ldv;
            pc_inc  = 1'b1;
          end
          mjq_pkg::OP_ADD, mjq_pkg::OP_SUB: begin
            wr_en   = 1'b1;
            wr_data = alu_v;
            ov_set  = alu_ov;
            pc_inc  = 1'b1;
          end
          mjq_pkg::OP_KMUL: begin
            wr_en   = 1'b1;
            wr_data = kres[63:0];
            ov_set  = kres[64];
            pc_inc  = 1'b1;
          end
          mjq_pkg::OP_MUL: mul_start = 1'b1;
          mjq_pkg::OP_DIV: div_start = 1'b1;
          mjq_pkg::OP_ST: begin
            st_en  = 1'b1;
            ov_set = sto[32];
            pc_inc = 1'b1;
          end
          mjq_pkg::OP_END: fin = 1'b1;
          default: fin = 1'b0;
        endcase
      end
      mjq_pkg::BK_WAIT: begin
        if (ures.done) begin
          wr_en   = 1'b1;
          wr_data = ures.value;
          ov_set  = ures.ov;
          pc_inc  = 1'b1;
        end
      end
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mjq_pkg::BK_IDLE;
      pc    <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin || (pop && head.job.trivial);
      if (fin) begin
        pc <= '0;
      end else if (pc_inc) begin
        pc <= pc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head.job;
      ov  <= 1'b0;
    end else if (ov_set) begin
      ov <= 1'b1;
    end
    if (pop && head.job.trivial) begin
      result.pos_out       <= head.job.item.start_pos;
      result.vel_out       <= head.job.item.start_vel;
      result.acc_out       <= head.job.item.start_acc;
      result.overflow_flag <= 1'b1;
    end else if (st_en) begin
      case (u.k)
        5'd0:    result.pos_out <= sto[31:0];
        5'd1:    result.vel_out <= sto[31:0];
        default: result.acc_out <= sto[31:0];
      endcase
    end else if (fin) begin
      result.overflow_flag <= ov;
    end
  end

  a_wait_unit: assert property (@(posedge clk) disable iff (rst)
    state == mjq_pkg::BK_WAIT |-> (u.op == mjq_pkg::OP_MUL || u.op == mjq_pkg::OP_DIV))
    else $error("waiting on a unit for an op that uses none");
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> ($past(state) == mjq_pkg::BK_EXEC || $past(state) == mjq_pkg::BK_IDLE))
    else $error("result strobe from an unexpected state");
  a_trivial_flag: assert property (@(posedge clk) disable iff (rst)
    (pop && head.job.trivial) |=> (done && result.overflow_flag))
    else $error("zero-duration transaction not flagged");

endmodule

// ===== rtl/min_jerk_quintic_trajectory_unit.sv =====
// A zero-duration transaction is answered straight from the idle back end, with no
// arithmetic; a full evaluation is paced by the bit-serial divider (4 divisions), the
// shared 4-pass multiplier (16 products) and 54 further micro-program steps. The back end
// works on one transaction at a time; the 2-entry queue takes new transactions meanwhile.
// The receiver cannot stall. Reset (rst, synchronous, active high) empties the queue.
module min_jerk_quintic_trajectory_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mjq_pkg::item_t    item,
  output logic              done,
  output mjq_pkg::result_t  result
);

  // The front end classifies each transaction (zero duration or full evaluation) and
  // queues it; busy rises only when the queue is full, so acceptance does not wait on
  // the arithmetic in progress.
  mjq_pkg::queue_head_t head;
  logic                 pop;

  mjq_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .pop   (pop),
    .head  (head)
  );

  // The back end runs a fixed micro-program over a small register store: saturating
  // add/subtract and constant multiplies take one step each, products and quotients go
  // to the multi-cycle multiplier and divider. The result register is loaded field by
  // field and presented with a one-cycle done strobe.
  mjq_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule
